FILE: rtl/assert_macros.svh
// Assertion macros shared by the block cipher RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define FBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define FBC_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: rtl/fbc_pkg.sv
// Package for the 128-bit Feistel block cipher: types, constants, helpers.
// Used by every module of the block; depends on nothing.
package fbc_pkg;

    localparam int TABLE_BYTES = 256;
    localparam int TBL_WORDS   = 64;

    localparam logic [1:0] CMD_KEY = 2'd0;
    localparam logic [1:0] CMD_ENC = 2'd1;
    localparam logic [1:0] CMD_DEC = 2'd2;

    typedef logic [7:0][31:0] wht_t;

    localparam wht_t WHITE_CONST = {
        32'h5DBD8EA0, 32'hCF34D1A8, 32'h60B9E2BF, 32'h5C908450,
        32'hFE210D89, 32'h8BCDAA75, 32'h97353B17, 32'h93B3A436
    };

    typedef struct packed {
        logic [5:0]  raddr;
        logic        we;
        logic [5:0]  waddr;
        logic [31:0] wdata;
    } tbl_req_t;

    function automatic logic [31:0] round_f(input logic [31:0] x, input logic [31:0] k);
        logic [31:0] r8;
        logic [31:0] r16;
        logic [31:0] r24;
        r8  = {x[7:0], x[31:8]};
        r16 = {x[15:0], x[31:16]};
        r24 = {x[23:0], x[31:24]};
        return (x ^ k) + r8 + r16 + r24;
    endfunction

    function automatic logic [7:0] get_byte(input logic [31:0] w, input logic [1:0] lane);
        return w[lane*8 +: 8];
    endfunction

    function automatic logic [31:0] set_byte(input logic [31:0] w, input logic [1:0] lane,
                                             input logic [7:0] v);
        logic [31:0] r;
        r = w;
        r[lane*8 +: 8] = v;
        return r;
    endfunction

endpackage

FILE: rtl/fbc_table.sv
// Round table memory: 64 words of 32 bits, one write and one registered read port.
// Depends on fbc_pkg; reads as zero until the first identity fill has completed.
module fbc_table (
    input  logic             clk,
    input  logic             rst_n,
    input  fbc_pkg::tbl_req_t req,
    input  logic             mark_loaded,
    output logic [31:0]      rdata
);
    import fbc_pkg::*;

    logic [31:0] mem [TBL_WORDS];
    logic [31:0] q_reg;
    logic        loaded_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        q_reg <= mem[req.raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= 1'b0;
        end
        else if (mark_loaded)
        begin
            loaded_reg <= 1'b1;
        end
    end

    // Before any key the table is defined to be all zero.
    assign rdata = loaded_reg ? q_reg : '0;

endmodule

FILE: rtl/fbc_keysched.sv
// Key collection and key schedule sequencer for the block cipher.
// Depends on fbc_pkg and assert_macros.svh; drives the round table memory.
`include "assert_macros.svh"
module fbc_keysched (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              key_wr,
    input  logic [7:0]        key_byte,
    input  logic              key_last,
    output fbc_pkg::tbl_req_t tbl,
    input  logic [31:0]       tbl_rdata,
    output logic              mark_loaded,
    output fbc_pkg::wht_t     wh,
    output logic              busy
);
    import fbc_pkg::*;

    typedef enum logic [7:0] {
        KS_IDLE = 8'b00000001,
        KS_INIT = 8'b00000010,
        KS_RI   = 8'b00000100,
        KS_RK   = 8'b00001000,
        KS_WI   = 8'b00010000,
        KS_WJ   = 8'b00100000,
        KS_XOR  = 8'b01000000,
        KS_WHT  = 8'b10000000
    } ks_state_t;

    ks_state_t        state_reg, state_next;
    logic [8:0]       kcount_reg, kcount_next;
    logic [8:0]       len_reg, len_next;
    logic [7:0]       i_reg, i_next;
    logic [7:0]       j_reg, j_next;
    logic [7:0]       kidx_reg, kidx_next;
    logic [7:0]       a_reg, a_next;
    logic [31:0]      wi_reg, wi_next;
    logic [31:0]      wj_reg, wj_next;
    logic [2:0]       lane_reg, lane_next;
    logic [23:0]      mask_reg, mask_next;
    logic [3:0][31:0] acc_reg, acc_next;
    wht_t             wh_reg, wh_next;

    logic [7:0]  kmem [TABLE_BYTES];
    logic [7:0]  kq_reg;
    logic [8:0]  kidx_p1;
    logic [7:0]  kidx_inc;
    logic [7:0]  a_byte;
    logic [7:0]  b_byte;
    logic [7:0]  j_sum;
    logic [31:0] wmod;
    logic [31:0] wbase;
    logic [31:0] xword;

    always_ff @(posedge clk)
    begin
        if (key_wr && (state_reg == KS_IDLE) && !kcount_reg[8])
        begin
            kmem[kcount_reg[7:0]] <= key_byte;
        end
        kq_reg <= kmem[kidx_reg];
    end

    // Key index runs modulo the key length without a divider.
    assign kidx_p1  = {1'b0, kidx_reg} + 9'd1;
    assign kidx_inc = (kidx_p1 == len_reg) ? 8'd0 : kidx_p1[7:0];

    assign a_byte = get_byte(tbl_rdata, i_reg[1:0]);
    assign b_byte = get_byte(tbl_rdata, j_reg[1:0]);
    assign j_sum  = kq_reg + a_byte + j_reg;
    assign wmod   = set_byte(wi_reg, i_reg[1:0], b_byte);
    assign wbase  = (j_reg[7:2] == i_reg[7:2]) ? wi_reg : wj_reg;
    assign xword  = wi_reg ^ {kq_reg, mask_reg};

    always_comb
    begin
        state_next  = state_reg;
        kcount_next = kcount_reg;
        len_next    = len_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        kidx_next   = kidx_reg;
        a_next      = a_reg;
        wi_next     = wi_reg;
        wj_next     = wj_reg;
        lane_next   = lane_reg;
        mask_next   = mask_reg;
        acc_next    = acc_reg;
        wh_next     = wh_reg;
        mark_loaded = 1'b0;
        tbl         = '0;
        case (state_reg)
            KS_IDLE:
            begin
                if (key_wr)
                begin
                    if (!kcount_reg[8])
                    begin
                        kcount_next = kcount_reg + 9'd1;
                    end
                    if (key_last)
                    begin
                        len_next    = kcount_reg + {8'd0, !kcount_reg[8]};
                        kcount_next = '0;
                        i_next      = '0;
                        state_next  = KS_INIT;
                    end
                end
            end
            KS_INIT:
            begin
                tbl.we    = 1'b1;
                tbl.waddr = i_reg[5:0];
                tbl.wdata = {i_reg[5:0], 2'd3, i_reg[5:0], 2'd2,
                             i_reg[5:0], 2'd1, i_reg[5:0], 2'd0};
                if (i_reg[5:0] == 6'd63)
                begin
                    mark_loaded = 1'b1;
                    i_next      = '0;
                    j_next      = '0;
                    kidx_next   = '0;
                    state_next  = KS_RI;
                end
                else
                begin
                    i_next = i_reg + 8'd1;
                end
            end
            KS_RI:
            begin
                tbl.raddr  = i_reg[7:2];
                state_next = KS_RK;
            end
            KS_RK:
            begin
                a_next     = a_byte;
                j_next     = j_sum;
                wi_next    = tbl_rdata;
                tbl.raddr  = j_sum[7:2];
                state_next = KS_WI;
            end
            KS_WI:
            begin
                tbl.we     = 1'b1;
                tbl.waddr  = i_reg[7:2];
                tbl.wdata  = wmod;
                wi_next    = wmod;
                wj_next    = tbl_rdata;
                state_next = KS_WJ;
            end
            KS_WJ:
            begin
                // When both bytes share a word, the word just written is the base.
                tbl.we    = 1'b1;
                tbl.waddr = j_reg[7:2];
                tbl.wdata = set_byte(wbase, j_reg[1:0], a_reg);
                kidx_next = kidx_inc;
                if (i_reg == 8'd255)
                begin
                    i_next     = '0;
                    kidx_next  = '0;
                    lane_next  = '0;
                    acc_next   = '0;
                    state_next = KS_XOR;
                end
                else
                begin
                    i_next     = i_reg + 8'd1;
                    state_next = KS_RI;
                end
            end
            KS_XOR:
            begin
                tbl.raddr = i_reg[5:0];
                if (lane_reg != 3'd4)
                begin
                    kidx_next = kidx_inc;
                    lane_next = lane_reg + 3'd1;
                end
                case (lane_reg)
                    3'd1:
                    begin
                        wi_next         = tbl_rdata;
                        mask_next[7:0]  = kq_reg;
                    end
                    3'd2:
                    begin
                        mask_next[15:8] = kq_reg;
                    end
                    3'd3:
                    begin
                        mask_next[23:16] = kq_reg;
                    end
                    3'd4:
                    begin
                        tbl.we    = 1'b1;
                        tbl.waddr = i_reg[5:0];
                        tbl.wdata = xword;
                        acc_next[i_reg[1:0]] = acc_reg[i_reg[1:0]] ^ xword;
                        lane_next = '0;
                        if (i_reg[5:0] == 6'd63)
                        begin
                            state_next = KS_WHT;
                        end
                        else
                        begin
                            i_next = i_reg + 8'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            KS_WHT:
            begin
                for (int n = 0; n < 4; n++)
                begin
                    wh_next[n]     = WHITE_CONST[n] ^ acc_reg[n];
                    wh_next[4 + n] = WHITE_CONST[4 + n] ^ acc_reg[n];
                end
                state_next = KS_IDLE;
            end
            default:
            begin
                state_next = KS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= KS_IDLE;
            kcount_reg <= '0;
            wh_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            kcount_reg <= kcount_next;
            wh_reg     <= wh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        kidx_reg <= kidx_next;
        a_reg    <= a_next;
        wi_reg   <= wi_next;
        wj_reg   <= wj_next;
        lane_reg <= lane_next;
        mask_reg <= mask_next;
        acc_reg  <= acc_next;
    end

    assign wh   = wh_reg;
    assign busy = (state_reg != KS_IDLE);

    `FBC_NEVER(a_kcount_range, kcount_reg > 9'd256, "key count beyond table size")
endmodule

FILE: rtl/fbc_cipher.sv
// Round datapath of the block cipher: whitening, 2*ROUNDS key reads, result hold.
// Depends on fbc_pkg and assert_macros.svh; reads round keys from the table memory.
`include "assert_macros.svh"
module fbc_cipher #(
    parameter int ROUNDS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          dec,
    input  logic [31:0]   in_w0,
    input  logic [31:0]   in_w1,
    input  logic [31:0]   in_w2,
    input  logic [31:0]   in_w3,
    input  fbc_pkg::wht_t wh,
    input  logic [31:0]   tbl_rdata,
    output logic [5:0]    tbl_raddr,
    output logic          res_valid,
    input  logic          res_ack,
    output logic [31:0]   res_w0,
    output logic [31:0]   res_w1,
    output logic [31:0]   res_w2,
    output logic [31:0]   res_w3,
    output logic          busy
);
    import fbc_pkg::*;

    localparam int CW = $clog2(2 * ROUNDS + 1);

    typedef enum logic [3:0] {
        CI_IDLE = 4'b0001,
        CI_RUN  = 4'b0010,
        CI_WHT  = 4'b0100,
        CI_HOLD = 4'b1000
    } ci_state_t;

    ci_state_t     state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          dec_reg, dec_next;
    logic [31:0]   l0_reg, l0_next;
    logic [31:0]   r0_reg, r0_next;
    logic [31:0]   l1_reg, l1_next;
    logic [31:0]   r1_reg, r1_next;

    logic [CW-1:0] rnd;
    logic [5:0]    rsel;
    logic [31:0]   fx;
    logic [31:0]   fo;
    logic          k0_cycle;

    // Key index cnt selects word cnt for encryption; decryption walks rounds backward.
    assign rnd       = cnt_reg >> 1;
    assign rsel      = dec_reg ? (6'(ROUNDS - 1) - 6'(rnd)) : 6'(rnd);
    assign tbl_raddr = {rsel[4:0], cnt_reg[0]};

    // Data of key 2r arrives when cnt is odd, key 2r+1 when cnt is even.
    assign k0_cycle = cnt_reg[0];
    assign fx = k0_cycle ? (dec_reg ? r1_reg : l0_reg) : l1_reg;
    assign fo = round_f(fx, tbl_rdata);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dec_next   = dec_reg;
        l0_next    = l0_reg;
        r0_next    = r0_reg;
        l1_next    = l1_reg;
        r1_next    = r1_reg;
        case (state_reg)
            CI_IDLE:
            begin
                if (start)
                begin
                    dec_next   = dec;
                    cnt_next   = '0;
                    l0_next    = in_w0 ^ (dec ? wh[4] : wh[0]);
                    r0_next    = in_w1 ^ (dec ? wh[5] : wh[1]);
                    l1_next    = in_w2 ^ (dec ? wh[6] : wh[2]);
                    r1_next    = in_w3 ^ (dec ? wh[7] : wh[3]);
                    state_next = CI_RUN;
                end
            end
            CI_RUN:
            begin
                if (cnt_reg != '0)
                begin
                    if (k0_cycle)
                    begin
                        if (dec_reg)
                        begin
                            l0_next = r1_reg;
                            r1_next = l1_reg;
                            l1_next = r0_reg;
                            r0_next = l0_reg - fo;
                        end
                        else
                        begin
                            r0_next = r0_reg + fo;
                        end
                    end
                    else
                    begin
                        if (dec_reg)
                        begin
                            r1_next = r1_reg - fo;
                        end
                        else
                        begin
                            l0_next = r0_reg;
                            r0_next = l1_reg;
                            l1_next = r1_reg + fo;
                            r1_next = l0_reg;
                        end
                    end
                end
                if (cnt_reg == CW'(2 * ROUNDS))
                begin
                    state_next = CI_WHT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            CI_WHT:
            begin
                l0_next    = l0_reg ^ (dec_reg ? wh[0] : wh[4]);
                r0_next    = r0_reg ^ (dec_reg ? wh[1] : wh[5]);
                l1_next    = l1_reg ^ (dec_reg ? wh[2] : wh[6]);
                r1_next    = r1_reg ^ (dec_reg ? wh[3] : wh[7]);
                state_next = CI_HOLD;
            end
            CI_HOLD:
            begin
                if (res_ack)
                begin
                    state_next = CI_IDLE;
                end
            end
            default:
            begin
                state_next = CI_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CI_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dec_reg <= dec_next;
        l0_reg  <= l0_next;
        r0_reg  <= r0_next;
        l1_reg  <= l1_next;
        r1_reg  <= r1_next;
    end

    assign res_valid = (state_reg == CI_HOLD);
    assign busy      = (state_reg != CI_IDLE);
    assign res_w0    = l0_reg;
    assign res_w1    = r0_reg;
    assign res_w2    = l1_reg;
    assign res_w3    = r1_reg;

    `FBC_ASSERT(a_hold_stable, (res_valid && !res_ack) |=> (res_valid && $stable(res_w0)
        && $stable(res_w3)), "result changed while waiting for the output register")
    `FBC_NEVER(a_start_busy, start && busy, "block started while the datapath is busy")
endmodule

FILE: rtl/feistel_block_cipher_128_top.sv
// Top level of the 128-bit Feistel block cipher with a byte-serial key schedule.
// Depends on fbc_pkg, fbc_table, fbc_keysched, fbc_cipher and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per command:
//   cmd 0 loads key_byte (key_last starts the schedule), cmd 1 encrypts and
//   cmd 2 decrypts the block in_w0..in_w3; cmd 3 is dropped.
//   Output channel (out_valid / out_stall) returns one block per encrypt or
//   decrypt transaction in out_w0..out_w3; key transactions return nothing.
//   A key byte without key_last leaves in_stall low. The schedule that key_last
//   starts fills the table with the identity, swaps table bytes under the key,
//   XORs key bytes into every table word and then sets the whitening, all on
//   the round table memory, and in_stall is high meanwhile. A block reads two
//   round keys per round from the table memory at one word per cycle, then
//   whitens the result and holds it until it enters the output register;
//   out_valid rises at that same edge. One block is in the datapath at a time.
//   A finished block waits in the datapath while the output register is held
//   by out_stall, and in_stall stays high until it has moved on.
//   After reset the key count is zero and the table and whitening read as
//   zero, so blocks may be processed before any key is loaded.
`include "assert_macros.svh"
module feistel_block_cipher_128_top #(
    parameter int ROUNDS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  key_byte,
    input  logic        key_last,
    input  logic [31:0] in_w0,
    input  logic [31:0] in_w1,
    input  logic [31:0] in_w2,
    input  logic [31:0] in_w3,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_w0,
    output logic [31:0] out_w1,
    output logic [31:0] out_w2,
    output logic [31:0] out_w3
);
    import fbc_pkg::*;

    logic        in_acc;
    logic        key_wr;
    logic        blk_start;
    logic        ks_busy;
    logic        ci_busy;
    logic        mark_loaded;
    tbl_req_t    ks_tbl;
    tbl_req_t    tbl_req;
    logic [5:0]  ci_raddr;
    logic [31:0] tbl_rdata;
    wht_t        wh;
    logic        res_valid;
    logic        res_ack;
    logic [31:0] res_w0;
    logic [31:0] res_w1;
    logic [31:0] res_w2;
    logic [31:0] res_w3;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_w0_reg;
    logic [31:0] out_w1_reg;
    logic [31:0] out_w2_reg;
    logic [31:0] out_w3_reg;

    assign in_stall  = ks_busy || ci_busy;
    assign in_acc    = in_valid && !in_stall;
    assign key_wr    = in_acc && (cmd == CMD_KEY);
    assign blk_start = in_acc && ((cmd == CMD_ENC) || (cmd == CMD_DEC));

    // The schedule owns the table while it runs; otherwise the datapath reads it.
    always_comb
    begin
        tbl_req = ks_tbl;
        if (!ks_busy)
        begin
            tbl_req.raddr = ci_raddr;
        end
    end

    fbc_table u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (tbl_req),
        .mark_loaded (mark_loaded),
        .rdata       (tbl_rdata)
    );

    fbc_keysched u_keysched (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_wr      (key_wr),
        .key_byte    (key_byte),
        .key_last    (key_last),
        .tbl         (ks_tbl),
        .tbl_rdata   (tbl_rdata),
        .mark_loaded (mark_loaded),
        .wh          (wh),
        .busy        (ks_busy)
    );

    fbc_cipher #(
        .ROUNDS (ROUNDS)
    ) u_cipher (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (blk_start),
        .dec       (cmd == CMD_DEC),
        .in_w0     (in_w0),
        .in_w1     (in_w1),
        .in_w2     (in_w2),
        .in_w3     (in_w3),
        .wh        (wh),
        .tbl_rdata (tbl_rdata),
        .tbl_raddr (ci_raddr),
        .res_valid (res_valid),
        .res_ack   (res_ack),
        .res_w0    (res_w0),
        .res_w1    (res_w1),
        .res_w2    (res_w2),
        .res_w3    (res_w3),
        .busy      (ci_busy)
    );

    assign res_ack = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ack)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            out_w0_reg <= res_w0;
            out_w1_reg <= res_w1;
            out_w2_reg <= res_w2;
            out_w3_reg <= res_w3;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_w0    = out_w0_reg;
    assign out_w1    = out_w1_reg;
    assign out_w2    = out_w2_reg;
    assign out_w3    = out_w3_reg;

    `FBC_NEVER(a_one_owner, ks_busy && ci_busy, "schedule and datapath active together")
    `FBC_ASSERT(a_start_stalls, blk_start |=> in_stall, "block accepted without stalling input")
endmodule

FILE: tb/feistel_block_cipher_128_top_tb.sv
// Self-checking testbench for the 128-bit Feistel block cipher top level.
// Depends on fbc_pkg and feistel_block_cipher_128_top; predicts every block
// from a model of the key schedule and the rounds kept inside this file.
module feistel_block_cipher_128_top_tb;
    import fbc_pkg::*;

    localparam int NROUNDS = 32;
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  kb;
        logic        kl;
        logic [31:0] w [4];
    } cmd_item_t;

    typedef struct {
        logic [31:0] w [4];
    } block_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [31:0] in_w0, in_w1, in_w2, in_w3;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] out_w0, out_w1, out_w2, out_w3;

    cmd_item_t pending_cmds[$];
    block_t    expected_blocks[$];

    logic [7:0]  key_bytes [256];
    int          key_len;
    logic [7:0]  sbox [256];
    logic [31:0] white [8];

    bit   failed;
    bit   busy_phase;
    int   cycles;
    int   idle_pct;

    feistel_block_cipher_128_top #(.ROUNDS(NROUNDS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .key_byte(key_byte), .key_last(key_last),
        .in_w0(in_w0), .in_w1(in_w1), .in_w2(in_w2), .in_w3(in_w3),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_w0(out_w0), .out_w1(out_w1), .out_w2(out_w2), .out_w3(out_w3)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] sbox_word(input int off);
        return {sbox[(off + 3) & 8'hFF], sbox[(off + 2) & 8'hFF],
                sbox[(off + 1) & 8'hFF], sbox[off & 8'hFF]};
    endfunction

    function automatic logic [31:0] mix(input logic [31:0] x, input logic [31:0] k);
        return (x ^ k) + {x[7:0], x[31:8]} + {x[15:0], x[31:16]} + {x[23:0], x[31:24]};
    endfunction

    task automatic expand_key(input int len);
        int j;
        logic [7:0] t;
        logic [31:0] acc;
        j = 0;
        for (int i = 0; i < 256; i++)
            sbox[i] = i[7:0];
        for (int i = 0; i < 256; i++)
        begin
            j = (key_bytes[i % len] + sbox[i] + j) & 8'hFF;
            t = sbox[i];
            sbox[i] = sbox[j];
            sbox[j] = t;
        end
        for (int i = 0; i < 256; i++)
            sbox[i] ^= key_bytes[i % len];
        for (int c = 0; c < 4; c++)
        begin
            acc = '0;
            for (int w = 0; w < 64; w += 4)
                acc ^= sbox_word((c + w) * 4);
            white[c] = WHITE_CONST[c] ^ acc;
            white[4 + c] = WHITE_CONST[4 + c] ^ acc;
        end
    endtask

    // Applies one accepted transaction to the cipher model.
    task automatic cipher_accept(input cmd_item_t it);
        logic [31:0] l0, r0, l1, r1, t;
        block_t b;
        int pos;
        if (it.op == CMD_KEY)
        begin
            if (key_len < 256)
            begin
                key_bytes[key_len] = it.kb;
                key_len++;
            end
            if (it.kl)
            begin
                expand_key(key_len);
                key_len = 0;
            end
        end
        else if (it.op != CMD_NONE)
        begin
            l0 = it.w[0]; r0 = it.w[1]; l1 = it.w[2]; r1 = it.w[3];
            if (it.op == CMD_ENC)
            begin
                l0 ^= white[0]; r0 ^= white[1]; l1 ^= white[2]; r1 ^= white[3];
                for (int r = 0; r < NROUNDS; r++)
                begin
                    pos = (8 * r) & 8'hFF;
                    t = l0;
                    r0 += mix(l0, sbox_word(pos));
                    r1 += mix(l1, sbox_word(pos + 4));
                    l0 = r0; r0 = l1; l1 = r1; r1 = t;
                end
                l0 ^= white[4]; r0 ^= white[5]; l1 ^= white[6]; r1 ^= white[7];
            end
            else
            begin
                l0 ^= white[4]; r0 ^= white[5]; l1 ^= white[6]; r1 ^= white[7];
                for (int r = 0; r < NROUNDS; r++)
                begin
                    pos = (8 * (NROUNDS - 1 - r)) & 8'hFF;
                    t = l0;
                    l0 = r1; r1 = l1; l1 = r0; r0 = t;
                    r0 -= mix(l0, sbox_word(pos));
                    r1 -= mix(l1, sbox_word(pos + 4));
                end
                l0 ^= white[0]; r0 ^= white[1]; l1 ^= white[2]; r1 ^= white[3];
            end
            b.w[0] = l0; b.w[1] = r0; b.w[2] = l1; b.w[3] = r1;
            expected_blocks.push_back(b);
        end
    endtask

    function automatic cmd_item_t make_block(input logic [1:0] op);
        cmd_item_t it;
        it.op = op;
        it.kb = $urandom;
        it.kl = $urandom;
        for (int i = 0; i < 4; i++)
            it.w[i] = $urandom;
        return it;
    endfunction

    task automatic push_key(input int len, input bit all_ones);
        cmd_item_t it;
        for (int i = 0; i < len; i++)
        begin
            it = make_block(CMD_KEY);
            it.kb = all_ones ? 8'hFF : $urandom;
            it.kl = (i == len - 1);
            pending_cmds.push_back(it);
        end
    endtask

    function automatic cmd_item_t random_item();
        int sel;
        cmd_item_t it;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            it = make_block(CMD_ENC);
        else if (sel < 90)
            it = make_block(CMD_DEC);
        else if (sel < 95)
        begin
            it = make_block(CMD_KEY);
            it.kl = 1'b0;
        end
        else
            it = make_block(CMD_NONE);
        return it;
    endfunction

    // Driver: takes the next pending transaction when the current one is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd <= CMD_KEY;
            key_byte <= '0;
            key_last <= 1'b0;
            {in_w0, in_w1, in_w2, in_w3} <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                cipher_accept('{cmd, key_byte, key_last, '{in_w0, in_w1, in_w2, in_w3}});
            if (pending_cmds.size() > 0 && !busy_phase
                && $urandom_range(0, 99) >= idle_pct)
            begin
                cmd_item_t it;
                it = pending_cmds.pop_front();
                in_valid <= 1'b1;
                cmd <= it.op;
                key_byte <= it.kb;
                key_last <= it.kl;
                in_w0 <= it.w[0];
                in_w1 <= it.w[1];
                in_w2 <= it.w[2];
                in_w3 <= it.w[3];
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: checks each accepted result block against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_blocks.size() == 0)
                begin
                    $error("result block with nothing expected");
                    failed = 1'b1;
                end
                else
                begin
                    block_t e;
                    logic [31:0] got [4];
                    e = expected_blocks.pop_front();
                    got = '{out_w0, out_w1, out_w2, out_w3};
                    for (int i = 0; i < 4; i++)
                        if (got[i] !== e.w[i])
                        begin
                            $error("out_w%0d expected %h actual %h", i, e.w[i], got[i]);
                            failed = 1'b1;
                        end
                end
            end
            out_stall <= ($urandom_range(0, 99) < idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        cmd_item_t it;
        int n;
        int klen;
        cycles = 0;
        failed = 1'b0;
        busy_phase = 1'b0;
        idle_pct = 32;
        key_len = 0;
        for (int i = 0; i < 256; i++)
            sbox[i] = '0;
        for (int i = 0; i < 8; i++)
            white[i] = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Blocks before any key run with a zero table and zero whitening.
        it = make_block(CMD_ENC);
        it.w = '{32'h0, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF};
        pending_cmds.push_back(it);
        it = make_block(CMD_DEC);
        it.w = '{32'hFFFFFFFF, 32'h0, 32'h0, 32'hFFFFFFFF};
        pending_cmds.push_back(it);
        pending_cmds.push_back(make_block(CMD_NONE));
        // Shortest key, then a key of all 0xFF bytes.
        push_key(1, 1'b0);
        pending_cmds.push_back(make_block(CMD_ENC));
        pending_cmds.push_back(make_block(CMD_DEC));
        push_key(3, 1'b1);
        pending_cmds.push_back(make_block(CMD_ENC));
        pending_cmds.push_back(make_block(CMD_DEC));
        // Overlong key: bytes past 256 are dropped, the last still schedules.
        push_key(260, 1'b0);
        pending_cmds.push_back(make_block(CMD_ENC));
        pending_cmds.push_back(make_block(CMD_DEC));
        // Exactly 256 bytes.
        push_key(256, 1'b0);
        pending_cmds.push_back(make_block(CMD_DEC));

        // Every transaction counts, key bytes included.
        n = 0;
        while (n < 1000)
        begin
            if ($urandom_range(0, 99) < 3)
            begin
                klen = $urandom_range(1, 40);
                push_key(klen, 1'b0);
                n += klen;
            end
            it = random_item();
            pending_cmds.push_back(it);
            n++;
            // A stretch with no idling on either side.
            if (n >= 400 && n < 700)
                idle_pct = 0;
            else
                idle_pct = 32;
            while (pending_cmds.size() > 50)
                @(posedge clk);
        end
        while (pending_cmds.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_blocks.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (!failed && expected_blocks.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
